@@ rtl/pdt_pkg.sv @@
// Shared types, codes and default sizes for the protocol demux table.
package pdt_pkg;

    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_DEVICE_BITS  = 4;
    localparam int DEF_HANDLER_BITS = 8;
    localparam int PROTO_W          = 16;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_RECEIVE    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MATCH  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } pdt_state_t;

endpackage

@@ rtl/pdt_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
module pdt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/protocol_handler_demux_table_core.sv @@
// Top level of the protocol handler demux table: entry RAM, scan/shift sequencer, output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | operation handler_id protocol device_index
//          |           |                       | device_any promiscuous
//  out     | output    | out_valid / out_ready | status matched_handler last
//
// Register and an unused code need no scan; unregister and receive make one RAM read per entry,
// and an unregister hit moves each later entry down one place as it is read.
// A new item is taken only when the previous one has finished.
// Reset clears the state, the entry count and the valid flags; the table contents stay undefined and need no clearing.
// A held result on the output stalls a receive scan at any match after the first, and the final result, until taken.
module protocol_handler_demux_table_core #(
    parameter int TABLE_DEPTH  = pdt_pkg::DEF_TABLE_DEPTH,
    parameter int DEVICE_BITS  = pdt_pkg::DEF_DEVICE_BITS,
    parameter int HANDLER_BITS = pdt_pkg::DEF_HANDLER_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  handler_id,
    input  logic [15:0] protocol,
    input  logic [3:0]  device_index,
    input  logic        device_any,
    input  logic        promiscuous,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  matched_handler,
    output logic        last
);

    import pdt_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = HANDLER_BITS + PROTO_W + DEVICE_BITS + 2;

    pdt_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, rd_addr;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       stat_reg, stat_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [HANDLER_BITS-1:0] pend_h_reg, pend_h_next;

    logic [HANDLER_BITS-1:0] hid_reg, hid_next;
    logic [PROTO_W-1:0]      proto_reg, proto_next;
    logic [DEVICE_BITS-1:0]  dev_reg, dev_next;
    logic                    prom_reg, prom_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic [7:0] out_handler_reg, out_handler_next;
    logic       out_last_reg, out_last_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;

    logic                    e_prom, e_any;
    logic [DEVICE_BITS-1:0]  e_dev;
    logic [PROTO_W-1:0]      e_proto;
    logic [HANDLER_BITS-1:0] e_handler;

    logic [CNT_W-1:0] last_idx;
    logic             at_end, can_emit, in_accept, load, rx_match, advance;

    pdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign {e_handler, e_proto, e_dev, e_any, e_prom} = rd_data;

    assign last_idx  = count_reg - CNT_W'(1);
    assign at_end    = (CNT_W'(cur_reg) == last_idx);
    assign can_emit  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign rx_match = (e_any || (e_dev == dev_reg))
                   && ((e_proto == '0) || (e_proto == proto_reg))
                   && (e_prom == prom_reg);
    // hold the scan when a second match needs the output slot and it is still full
    assign advance  = !(rx_match && pend_valid_reg && !can_emit);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_addr          = cur_reg;
        op_next          = op_reg;
        stat_next        = stat_reg;
        pend_valid_next  = pend_valid_reg;
        pend_h_next      = pend_h_reg;
        hid_next         = hid_reg;
        proto_next       = proto_reg;
        dev_next         = dev_reg;
        prom_next        = prom_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_data          = {HANDLER_BITS'(handler_id), protocol,
                            DEVICE_BITS'(device_index), device_any, promiscuous};
        in_ready         = 1'b0;
        load             = 1'b0;
        out_status_next  = out_status_reg;
        out_handler_next = out_handler_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
                if (in_valid)
                begin
                    op_next         = operation;
                    hid_next        = HANDLER_BITS'(handler_id);
                    proto_next      = protocol;
                    dev_next        = DEVICE_BITS'(device_index);
                    prom_next       = promiscuous;
                    pend_valid_next = 1'b0;
                    unique case (operation)
                        OP_REGISTER:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                stat_next  = ST_OK;
                            end
                            state_next = S_DONE;
                        end
                        OP_UNREGISTER:
                        begin
                            stat_next  = ST_NOT_FOUND;
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        OP_RECEIVE:
                        begin
                            stat_next  = ST_NO_MATCH;
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_UNREGISTER)
                begin
                    if (e_handler == hid_reg)
                    begin
                        stat_next = ST_OK;
                        if (at_end)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_addr    = IDX_W'(cur_reg + 1'b1);
                            state_next = S_SHIFT;
                        end
                    end
                    else if (at_end)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr = IDX_W'(cur_reg + 1'b1);
                    end
                end
                else if (advance)
                begin
                    if (rx_match)
                    begin
                        // push the earlier match out, keep this one until the end is known
                        if (pend_valid_reg)
                        begin
                            load             = 1'b1;
                            out_status_next  = ST_OK;
                            out_handler_next = 8'(pend_h_reg);
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_h_next     = e_handler;
                    end
                    if (at_end)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr = IDX_W'(cur_reg + 1'b1);
                    end
                end
            end
            S_SHIFT:
            begin
                // move the entry just read down one place
                wr_en   = 1'b1;
                wr_addr = IDX_W'(cur_reg - 1'b1);
                wr_data = rd_data;
                if (at_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr = IDX_W'(cur_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    load             = 1'b1;
                    out_status_next  = pend_valid_reg ? ST_OK : stat_reg;
                    out_handler_next = pend_valid_reg ? 8'(pend_h_reg) : 8'd0;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= rd_addr;
        op_reg          <= op_next;
        stat_reg        <= stat_next;
        pend_h_reg      <= pend_h_next;
        hid_reg         <= hid_next;
        proto_reg       <= proto_next;
        dev_reg         <= dev_next;
        prom_reg        <= prom_next;
        out_status_reg  <= out_status_next;
        out_handler_reg <= out_handler_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign matched_handler = out_handler_reg;
    assign last            = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_SHIFT) || (in_accept && operation == OP_REGISTER)))
        else $error("table write outside register or shift");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_emit)
        else $error("result loaded over an untaken result");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (op_reg == OP_RECEIVE)
                        && ((state_reg == S_SCAN) || (state_reg == S_DONE)))
        else $error("pending match outside a receive scan");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && can_emit) |=> (out_valid && last))
        else $error("final result not marked last");
`endif

endmodule

@@ verif/tb_protocol_handler_demux_table_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the protocol handler demux table core.
module tb_protocol_handler_demux_table_core;
    import pdt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  hid;
        logic [15:0] proto;
        logic [3:0]  dev;
        logic        dev_any;
        logic        promisc;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] handler;
        logic       last;
    } dispatch_t;

    typedef struct packed {
        logic [7:0]  handler;
        logic [15:0] proto;
        logic [3:0]  dev;
        logic        dev_any;
        logic        promisc;
    } entry_t;

    typedef struct packed {
        req_t      req;
        logic [4:0] reps;
        logic      has_ref;
        dispatch_t ref_res;
    } row_t;

    localparam dispatch_t EXP_DONE      = {ST_OK, 8'h00, 1'b1};
    localparam dispatch_t EXP_NO_MATCH  = {ST_NO_MATCH, 8'h00, 1'b1};
    localparam dispatch_t EXP_FULL      = {ST_FULL, 8'h00, 1'b1};
    localparam dispatch_t EXP_NOT_FOUND = {ST_NOT_FOUND, 8'h00, 1'b1};
    localparam dispatch_t EXP_PREDICTED = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [7:0]  handler_id = '0;
    logic [15:0] protocol = '0;
    logic [3:0]  device_index = '0;
    logic        device_any = 1'b0;
    logic        promiscuous = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  matched_handler;
    logic        last;

    // Mirror of the handler table and the dispatch results still owed by the block
    entry_t      entries [DEPTH];
    int          entry_cnt = 0;
    dispatch_t   dispatch_q [$];
    dispatch_t   step_results [$];
    row_t        plan [$];
    int          send_idle_pct = 17;
    int          recv_idle_pct = 80;
    int          fail_count = 0;

    protocol_handler_demux_table_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .handler_id      (handler_id),
        .protocol        (protocol),
        .device_index    (device_index),
        .device_any      (device_any),
        .promiscuous     (promiscuous),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .matched_handler (matched_handler),
        .last            (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic entry_hit(input entry_t e, input req_t r);
        return (e.dev_any || e.dev == r.dev) && (e.proto == 16'h0 || e.proto == r.proto)
            && e.promisc == r.promisc;
    endfunction

    // Apply one item to the table mirror and collect the results it causes
    task automatic predict_dispatch(input req_t r);
        int hit;
        int hits;
        int k;
        int i;
        step_results.delete();
        case (r.op)
            OP_REGISTER:
            begin
                if (entry_cnt >= DEPTH)
                begin
                    step_results.insert(step_results.size(), EXP_FULL);
                end
                else
                begin
                    entries[entry_cnt] = {r.hid, r.proto, r.dev, r.dev_any, r.promisc};
                    entry_cnt++;
                    step_results.insert(step_results.size(), EXP_DONE);
                end
            end
            OP_UNREGISTER:
            begin
                hit = -1;
                for (i = 0; i < entry_cnt; i++)
                    if (hit < 0 && entries[i].handler == r.hid)
                        hit = i;
                if (hit < 0)
                begin
                    step_results.insert(step_results.size(), EXP_NOT_FOUND);
                end
                else
                begin
                    // close the gap
                    for (i = hit; i < entry_cnt - 1; i++)
                        entries[i] = entries[i + 1];
                    entry_cnt--;
                    step_results.insert(step_results.size(), EXP_DONE);
                end
            end
            OP_RECEIVE:
            begin
                hits = 0;
                for (i = 0; i < entry_cnt; i++)
                    if (entry_hit(entries[i], r))
                        hits++;
                k = 0;
                for (i = 0; i < entry_cnt; i++)
                begin
                    if (entry_hit(entries[i], r))
                    begin
                        k++;
                        step_results.insert(step_results.size(),
                                            {ST_OK, entries[i].handler, k == hits});
                    end
                end
                if (hits == 0)
                    step_results.insert(step_results.size(), EXP_NO_MATCH);
            end
            default:
            begin
                // unused code: dropped without a result
            end
        endcase
    endtask

    function automatic logic [15:0] pick_proto();
        case ($urandom_range(2))
            0:       return 16'h0800;
            1:       return 16'h0806;
            default: return 16'h86DD;
        endcase
    endfunction

    // Mostly well-formed traffic against a small pool of ids, protocols and devices
    function automatic req_t random_req();
        req_t r;
        int   pick;
        int   e;
        r = $urandom;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            r.op = OP_UNUSED;
        end
        else if (pick < 42)
        begin
            r.op = OP_REGISTER;
            if ($urandom_range(3) != 0)
                r.hid = 8'($urandom_range(7));
            pick = $urandom_range(9);
            if (pick < 3)
                r.proto = 16'h0;
            else if (pick < 8)
                r.proto = pick_proto();
            if ($urandom_range(9) < 6)
                r.dev = 4'($urandom_range(3));
            r.dev_any = ($urandom_range(3) == 0);
            r.promisc = ($urandom_range(9) < 3);
        end
        else if (pick < 60)
        begin
            r.op = OP_UNREGISTER;
            if (entry_cnt > 0 && $urandom_range(3) != 0)
                r.hid = entries[$urandom_range(entry_cnt - 1)].handler;
            else if ($urandom_range(1) != 0)
                r.hid = 8'($urandom_range(7));
        end
        else
        begin
            r.op = OP_RECEIVE;
            if (entry_cnt > 0 && $urandom_range(9) < 7)
            begin
                e = $urandom_range(entry_cnt - 1);
                r.proto = (entries[e].proto != 16'h0) ? entries[e].proto : pick_proto();
                r.dev = entries[e].dev;
                r.promisc = entries[e].promisc;
            end
            else if ($urandom_range(1) != 0)
            begin
                r.proto = pick_proto();
            end
        end
        return r;
    endfunction

    // Enter and leave at a falling edge; predict at the accepting rising edge
    task automatic send_item(input req_t r, input logic has_ref, input dispatch_t ref_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {operation, handler_id, protocol, device_index, device_any, promiscuous} = r;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_dispatch(r);
        if (has_ref)
            dispatch_q.insert(dispatch_q.size(), ref_res);
        else
            foreach (step_results[k])
                dispatch_q.insert(dispatch_q.size(), step_results[k]);
        @(negedge clk);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] hid,
                           input logic [15:0] proto, input logic [3:0] dev,
                           input logic dev_any, input logic promisc, input int reps,
                           input logic has_ref, input dispatch_t ref_res);
        plan.insert(plan.size(),
                    {op, hid, proto, dev, dev_any, promisc, reps[4:0], has_ref, ref_res});
    endtask

    task automatic field_check(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
        out_ready = rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_output
        dispatch_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (dispatch_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual status %0d handler %0h last %0d",
                         $time, status, matched_handler, last);
                fail_count++;
            end
            else
            begin
                want = dispatch_q.pop_front();
                field_check("status", want.status, status);
                field_check("matched_handler", want.handler, matched_handler);
                field_check("last", want.last, last);
            end
        end
    end

    initial
    begin
        req_t r;
        row_t row;
        int   n;

        add_row(OP_RECEIVE,    8'h00, 16'h0000, 4'h0, 1'b0, 1'b0, 1,  1'b1, EXP_NO_MATCH);
        add_row(OP_UNREGISTER, 8'h00, 16'h0000, 4'h0, 1'b0, 1'b0, 1,  1'b1, EXP_NOT_FOUND);
        add_row(OP_UNUSED,     8'hFF, 16'hFFFF, 4'hF, 1'b1, 1'b1, 1,  1'b0, EXP_PREDICTED);
        add_row(OP_REGISTER,   8'hFF, 16'hFFFF, 4'hF, 1'b0, 1'b1, 1,  1'b1, EXP_DONE);
        add_row(OP_REGISTER,   8'h00, 16'h0000, 4'h0, 1'b1, 1'b0, 1,  1'b1, EXP_DONE);
        add_row(OP_REGISTER,   8'h5A, 16'h0800, 4'h3, 1'b0, 1'b0, 1,  1'b1, EXP_DONE);
        add_row(OP_REGISTER,   8'hA5, 16'h0800, 4'h4, 1'b1, 1'b0, 1,  1'b1, EXP_DONE);
        // receive ignores the id and any-device fields
        add_row(OP_RECEIVE,    8'hC3, 16'h0800, 4'h3, 1'b1, 1'b0, 1,  1'b0, EXP_PREDICTED);
        add_row(OP_RECEIVE,    8'h00, 16'hFFFF, 4'hF, 1'b0, 1'b1, 1,  1'b0, EXP_PREDICTED);
        add_row(OP_RECEIVE,    8'h3C, 16'h0806, 4'h7, 1'b0, 1'b0, 1,  1'b0, EXP_PREDICTED);
        add_row(OP_RECEIVE,    8'h00, 16'h1234, 4'h2, 1'b0, 1'b1, 1,  1'b1, EXP_NO_MATCH);
        // unregister ignores device and flags
        add_row(OP_UNREGISTER, 8'h5A, 16'h0800, 4'h3, 1'b1, 1'b1, 1,  1'b1, EXP_DONE);
        add_row(OP_UNREGISTER, 8'h5A, 16'h0000, 4'h0, 1'b0, 1'b0, 1,  1'b1, EXP_NOT_FOUND);
        add_row(OP_REGISTER,   8'h00, 16'h0800, 4'h3, 1'b0, 1'b0, 1,  1'b1, EXP_DONE);
        add_row(OP_UNREGISTER, 8'h00, 16'h0000, 4'h0, 1'b0, 1'b0, 1,  1'b1, EXP_DONE);
        add_row(OP_RECEIVE,    8'h00, 16'h0800, 4'h3, 1'b0, 1'b0, 1,  1'b0, EXP_PREDICTED);
        // fill the table, then overflow it
        add_row(OP_REGISTER,   8'h81, 16'h0000, 4'h9, 1'b1, 1'b0, 13, 1'b1, EXP_DONE);
        add_row(OP_REGISTER,   8'h7E, 16'h0001, 4'h1, 1'b0, 1'b0, 1,  1'b1, EXP_FULL);
        add_row(OP_RECEIVE,    8'h00, 16'h0800, 4'h3, 1'b0, 1'b0, 1,  1'b0, EXP_PREDICTED);
        add_row(OP_UNREGISTER, 8'hFF, 16'h0000, 4'h0, 1'b0, 1'b0, 1,  1'b1, EXP_DONE);
        add_row(OP_REGISTER,   8'h42, 16'h0000, 4'hA, 1'b1, 1'b0, 1,  1'b1, EXP_DONE);
        // every entry matches: longest burst of results
        add_row(OP_RECEIVE,    8'h00, 16'h0800, 4'h3, 1'b0, 1'b0, 1,  1'b0, EXP_PREDICTED);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            repeat (row.reps)
                send_item(row.req, row.has_ref, row.ref_res);
        end

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 80;
            end
            else if (n < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = random_req();
            send_item(r, 1'b0, EXP_PREDICTED);
            if (r.op != OP_UNUSED)
                n++;
        end
        in_valid = 1'b0;

        while (dispatch_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
